@@ hdl/fcik_pkg.sv @@
// Shared widths, register indexes and corner tables for the cable inverse kinematics core.
package fcik_pkg;

   // Input and register field widths
   localparam int unsigned POS_W      = 24;
   localparam int unsigned EDGE_W     = 24;
   localparam int unsigned OFFSET_W   = 23;
   localparam int unsigned SPM_W      = 24;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned STEPS_W    = 31;

   // Datapath widths
   localparam int unsigned DIFF_W         = POS_W + 1;
   localparam int unsigned AXIS_W         = POS_W + 2;
   localparam int unsigned SQ_W           = 2 * POS_W;
   localparam int unsigned SQZ_W          = 2 * POS_W - 1;
   localparam int unsigned SUM_W          = SQ_W + 2;
   localparam int unsigned RADICAND_SHIFT = 14;
   localparam int unsigned SQRT_IN_W      = SUM_W + RADICAND_SHIFT;
   localparam int unsigned ROOT_W         = SQRT_IN_W / 2;
   localparam int unsigned SQRT_STAGES    = ROOT_W;
   localparam int unsigned PROD_W         = ROOT_W + SPM_W;
   localparam int unsigned ROUND_SHIFT    = 31;
   localparam int unsigned RND_W          = PROD_W - ROUND_SHIFT;

   localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);
   localparam logic [STEPS_W-1:0] STEP_MAX   = '1;

   // Register reset values
   localparam logic signed [EDGE_W-1:0] EDGE_LOW_RESET  = {1'b1, {(EDGE_W-1){1'b0}}};
   localparam logic signed [EDGE_W-1:0] EDGE_HIGH_RESET = {1'b0, {(EDGE_W-1){1'b1}}};
   localparam logic [SPM_W-1:0]         SPM_RESET       = SPM_W'(65536);

   // Register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_MIN         = 3'd0,
      CSR_X_MAX         = 3'd1,
      CSR_Y_MIN         = 3'd2,
      CSR_Y_MAX         = 3'd3,
      CSR_CORNER_OFFSET = 3'd4,
      CSR_STEPS_PER_MM  = 3'd5
   } csr_index_type;

   // Frame edges
   localparam int unsigned NUM_EDGES  = 4;
   localparam int unsigned EDGE_IDX_W = 2;
   localparam logic [EDGE_IDX_W-1:0] EDGE_X_MIN = 2'd0;
   localparam logic [EDGE_IDX_W-1:0] EDGE_X_MAX = 2'd1;
   localparam logic [EDGE_IDX_W-1:0] EDGE_Y_MIN = 2'd2;
   localparam logic [EDGE_IDX_W-1:0] EDGE_Y_MAX = 2'd3;

   // Corners: top left, top right, bottom left, bottom right
   localparam int unsigned NUM_CORNERS = 4;
   localparam int unsigned CORNER_TL   = 0;
   localparam int unsigned CORNER_TR   = 1;
   localparam int unsigned CORNER_BL   = 2;
   localparam int unsigned CORNER_BR   = 3;

   localparam logic [EDGE_IDX_W-1:0] CORNER_X_EDGE [NUM_CORNERS] =
      '{EDGE_X_MIN, EDGE_X_MAX, EDGE_X_MIN, EDGE_X_MAX};
   localparam logic [EDGE_IDX_W-1:0] CORNER_Y_EDGE [NUM_CORNERS] =
      '{EDGE_Y_MAX, EDGE_Y_MAX, EDGE_Y_MIN, EDGE_Y_MIN};

   typedef logic [NUM_CORNERS-1:0][SQRT_IN_W-1:0] radicand_vec_type;
   typedef logic [NUM_CORNERS-1:0][ROOT_W-1:0]    root_vec_type;

endpackage

@@ hdl/fcik_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, four lanes in lockstep.
module fcik_sqrt_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  fcik_pkg::radicand_vec_type   in_radicand,
   output logic                         out_valid,
   input  logic                         out_ready,
   output fcik_pkg::root_vec_type       out_root
);
   import fcik_pkg::*;

   logic [SQRT_IN_W-1:0] rem_ff [SQRT_STAGES][NUM_CORNERS];
   logic [SQRT_IN_W-1:0] res_ff [SQRT_STAGES][NUM_CORNERS];
   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES:0]   ready;

   // Ready ripples back from the consumer; an empty stage always takes data
   assign ready[SQRT_STAGES] = out_ready;
   assign in_ready           = ready[0];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQRT_IN_W-1:0] STEP_BIT = SQRT_IN_W'(1) << (SQRT_IN_W - 2 - 2 * k);

      logic                 src_valid;
      logic [SQRT_IN_W-1:0] rem_src [NUM_CORNERS];
      logic [SQRT_IN_W-1:0] res_src [NUM_CORNERS];
      logic [SQRT_IN_W-1:0] trial   [NUM_CORNERS];
      logic [SQRT_IN_W-1:0] rem_in  [NUM_CORNERS];
      logic [SQRT_IN_W-1:0] res_in  [NUM_CORNERS];

      assign ready[k] = !valid_ff[k] || ready[k+1];

      // Select the stage source: the radicand for the first stage, the previous stage after it
      if (k == 0) begin : g_first
         always_comb begin
            src_valid = in_valid;
            for (int l = 0; l < NUM_CORNERS; l++) begin
               rem_src[l] = in_radicand[l];
               res_src[l] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            src_valid = valid_ff[k-1];
            for (int l = 0; l < NUM_CORNERS; l++) begin
               rem_src[l] = rem_ff[k-1][l];
               res_src[l] = res_ff[k-1][l];
            end
         end
      end

      // Try the next root bit; keep it when the remainder covers it
      always_comb begin
         for (int l = 0; l < NUM_CORNERS; l++) begin
            trial[l] = res_src[l] + STEP_BIT;
            if (rem_src[l] >= trial[l]) begin
               rem_in[l] = rem_src[l] - trial[l];
               res_in[l] = (res_src[l] >> 1) + STEP_BIT;
            end else begin
               rem_in[l] = rem_src[l];
               res_in[l] = res_src[l] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            for (int l = 0; l < NUM_CORNERS; l++) begin
               rem_ff[k][l] <= rem_in[l];
               res_ff[k][l] <= res_in[l];
            end
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];

   always_comb begin
      for (int l = 0; l < NUM_CORNERS; l++) begin
         out_root[l] = res_ff[SQRT_STAGES-1][l][ROOT_W-1:0];
      end
   end

endmodule

@@ hdl/four_cable_inverse_kinematics_core.sv @@
// Top level: cable inverse kinematics pipeline from a target point to four motor step counts.
//
// Each transaction on the req_ channel carries one point (mm, 8 fraction bits) and yields
// exactly one transaction on the rsp_ channel with the belt lengths of the four corner
// motors in steps, in the order the points went in. A new point is taken every cycle
// while req_stall is low. From acceptance to rsp_valid a point passes four stages for
// distances, squares and sums, 32 stages of the square root (one result bit per stage,
// which sets the depth), one stage for the steps-per-mm multiply and one for rounding
// and saturation. A stall on the rsp_ side fills empty stages first, so points are still
// taken until every stage holds one. Registers are written through the csr_ port and
// must only change while no point is in flight; writes to unknown indexes are ignored.
module four_cable_inverse_kinematics_core (
   input  logic                                clock,
   input  logic                                reset,
   // point input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fcik_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [fcik_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [fcik_pkg::POS_W-1:0]   req_pos_z,
   // step count output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fcik_pkg::STEPS_W-1:0]        rsp_steps_top_left,
   output logic [fcik_pkg::STEPS_W-1:0]        rsp_steps_top_right,
   output logic [fcik_pkg::STEPS_W-1:0]        rsp_steps_bottom_left,
   output logic [fcik_pkg::STEPS_W-1:0]        rsp_steps_bottom_right,
   // register writes
   input  logic                                csr_write_en,
   input  logic [fcik_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcik_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fcik_pkg::*;

   // Configuration registers
   logic signed [EDGE_W-1:0] edge_ff [NUM_EDGES];
   logic [OFFSET_W-1:0]      corner_offset_ff;
   logic [SPM_W-1:0]         steps_per_mm_ff;

   // Pipeline registers
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                     mul_valid_ff, rsp_valid_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff [NUM_EDGES];
   logic signed [POS_W-1:0]  s1_pos_z_ff;
   logic signed [AXIS_W-1:0] s2_axis_ff [NUM_EDGES];
   logic signed [POS_W-1:0]  s2_pos_z_ff;
   logic [SQ_W-1:0]          s3_sq_ff [NUM_EDGES];
   logic [SQZ_W-1:0]         s3_sq_z_ff;
   logic [SUM_W-1:0]         s4_sum_ff [NUM_CORNERS];
   logic [PROD_W-1:0]        mul_prod_ff [NUM_CORNERS];
   logic [STEPS_W-1:0]       rsp_steps_ff [NUM_CORNERS];

   // Next values
   logic signed [DIFF_W-1:0]   s1_diff_in [NUM_EDGES];
   logic signed [DIFF_W-1:0]   s2_mag     [NUM_EDGES];
   logic signed [AXIS_W-1:0]   s2_axis_in [NUM_EDGES];
   logic signed [2*AXIS_W-1:0] s3_prod    [NUM_EDGES];
   logic signed [2*POS_W-1:0]  s3_prod_z;
   logic [SUM_W-1:0]           s4_sum_in  [NUM_CORNERS];
   logic [PROD_W-1:0]          mul_prod_in [NUM_CORNERS];
   logic [PROD_W-1:0]          rnd_sum    [NUM_CORNERS];
   logic [RND_W-1:0]           rnd_steps  [NUM_CORNERS];
   logic [STEPS_W-1:0]         rsp_steps_in [NUM_CORNERS];

   // Handshake between stages
   logic             rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_mul, rdy_rsp;
   logic             sqrt_in_ready, sqrt_out_valid;
   radicand_vec_type sqrt_radicand;
   root_vec_type     sqrt_root;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff[EDGE_X_MIN] <= EDGE_LOW_RESET;
         edge_ff[EDGE_X_MAX] <= EDGE_HIGH_RESET;
         edge_ff[EDGE_Y_MIN] <= EDGE_LOW_RESET;
         edge_ff[EDGE_Y_MAX] <= EDGE_HIGH_RESET;
         corner_offset_ff    <= '0;
         steps_per_mm_ff     <= SPM_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_X_MIN:         edge_ff[EDGE_X_MIN] <= $signed(csr_wdata[EDGE_W-1:0]);
            CSR_X_MAX:         edge_ff[EDGE_X_MAX] <= $signed(csr_wdata[EDGE_W-1:0]);
            CSR_Y_MIN:         edge_ff[EDGE_Y_MIN] <= $signed(csr_wdata[EDGE_W-1:0]);
            CSR_Y_MAX:         edge_ff[EDGE_Y_MAX] <= $signed(csr_wdata[EDGE_W-1:0]);
            CSR_CORNER_OFFSET: corner_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            CSR_STEPS_PER_MM:  steps_per_mm_ff     <= csr_wdata[SPM_W-1:0];
            default: ;
         endcase
      end
   end

   // Ready ripples back from the output register
   assign rdy_rsp   = !rsp_valid_ff || !rsp_stall;
   assign rdy_mul   = !mul_valid_ff || rdy_rsp;
   assign rdy_s4    = !s4_valid_ff || sqrt_in_ready;
   assign rdy_s3    = !s3_valid_ff || rdy_s4;
   assign rdy_s2    = !s2_valid_ff || rdy_s3;
   assign rdy_s1    = !s1_valid_ff || rdy_s2;
   assign req_stall = !rdy_s1;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy_s1)  s1_valid_ff  <= req_valid;
         if (rdy_s2)  s2_valid_ff  <= s1_valid_ff;
         if (rdy_s3)  s3_valid_ff  <= s2_valid_ff;
         if (rdy_s4)  s4_valid_ff  <= s3_valid_ff;
         if (rdy_mul) mul_valid_ff <= sqrt_out_valid;
         if (rdy_rsp) rsp_valid_ff <= mul_valid_ff;
      end
   end

   // Stage 1: signed distance from each frame edge
   always_comb begin
      s1_diff_in[EDGE_X_MIN] = DIFF_W'(req_pos_x) - DIFF_W'(edge_ff[EDGE_X_MIN]);
      s1_diff_in[EDGE_X_MAX] = DIFF_W'(req_pos_x) - DIFF_W'(edge_ff[EDGE_X_MAX]);
      s1_diff_in[EDGE_Y_MIN] = DIFF_W'(req_pos_y) - DIFF_W'(edge_ff[EDGE_Y_MIN]);
      s1_diff_in[EDGE_Y_MAX] = DIFF_W'(req_pos_y) - DIFF_W'(edge_ff[EDGE_Y_MAX]);
   end

   // Stage 2: absolute distance minus the corner compensation, may go negative
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         s2_mag[e]     = (s1_diff_ff[e] < 0) ? -s1_diff_ff[e] : s1_diff_ff[e];
         s2_axis_in[e] = AXIS_W'(s2_mag[e]) - $signed(AXIS_W'(corner_offset_ff));
      end
   end

   // Stage 3: squares, exact
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         s3_prod[e] = s2_axis_ff[e] * s2_axis_ff[e];
      end
      s3_prod_z = s2_pos_z_ff * s2_pos_z_ff;
   end

   // Stage 4: sum of squares per corner
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         s4_sum_in[c] = SUM_W'(s3_sq_ff[CORNER_X_EDGE[c]]) + SUM_W'(s3_sq_ff[CORNER_Y_EDGE[c]])
                      + SUM_W'(s3_sq_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s1) begin
         s1_diff_ff  <= s1_diff_in;
         s1_pos_z_ff <= req_pos_z;
      end
      if (rdy_s2) begin
         s2_axis_ff  <= s2_axis_in;
         s2_pos_z_ff <= s1_pos_z_ff;
      end
      if (rdy_s3) begin
         for (int e = 0; e < NUM_EDGES; e++) begin
            s3_sq_ff[e] <= s3_prod[e][SQ_W-1:0];
         end
         s3_sq_z_ff <= s3_prod_z[SQZ_W-1:0];
      end
      if (rdy_s4) begin
         s4_sum_ff <= s4_sum_in;
      end
   end

   // Square root of the sum, scaled to mm with 15 fraction bits
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         sqrt_radicand[c] = {s4_sum_ff[c], {RADICAND_SHIFT{1'b0}}};
      end
   end

   fcik_sqrt_pipe u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s4_valid_ff),
      .in_ready    (sqrt_in_ready),
      .in_radicand (sqrt_radicand),
      .out_valid   (sqrt_out_valid),
      .out_ready   (rdy_mul),
      .out_root    (sqrt_root)
   );

   // Scale by steps per mm
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         mul_prod_in[c] = PROD_W'(sqrt_root[c]) * PROD_W'(steps_per_mm_ff);
      end
   end

   // Round half up and saturate
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         rnd_sum[c]   = mul_prod_ff[c] + ROUND_HALF;
         rnd_steps[c] = rnd_sum[c][PROD_W-1:ROUND_SHIFT];
         if (32'(rnd_steps[c]) > 32'(STEP_MAX)) begin
            rsp_steps_in[c] = STEP_MAX;
         end else begin
            rsp_steps_in[c] = STEPS_W'(rnd_steps[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_mul) begin
         mul_prod_ff <= mul_prod_in;
      end
      if (rdy_rsp) begin
         rsp_steps_ff <= rsp_steps_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_steps_top_left     = rsp_steps_ff[CORNER_TL];
   assign rsp_steps_top_right    = rsp_steps_ff[CORNER_TR];
   assign rsp_steps_bottom_left  = rsp_steps_ff[CORNER_BL];
   assign rsp_steps_bottom_right = rsp_steps_ff[CORNER_BR];

   // The input side stalls only while every stage holds a point
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff
                     && mul_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with an empty pipeline stage");

   // A free output never backs up into the input
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // An accepted point lands in the first stage
   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction lost at first stage");

   // Root and scale widths bound every count well below saturation
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_steps_ff[CORNER_TL][STEPS_W-1:RND_W] == '0
                        && rsp_steps_ff[CORNER_TR][STEPS_W-1:RND_W] == '0
                        && rsp_steps_ff[CORNER_BL][STEPS_W-1:RND_W] == '0
                        && rsp_steps_ff[CORNER_BR][STEPS_W-1:RND_W] == '0))
      else $error("step count exceeds the root times scale range");

endmodule

@@ tb/four_cable_inverse_kinematics_core_test.sv @@
// Testbench for the four-cable inverse kinematics core: predicted step counts per transaction.
module four_cable_inverse_kinematics_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fcik_pkg::*;

   typedef logic signed [POS_W-1:0]  coord_type;
   typedef logic signed [EDGE_W-1:0] rim_type;
   typedef longint unsigned          u64_type;

   typedef struct packed {
      logic [STEPS_W-1:0] top_left;
      logic [STEPS_W-1:0] top_right;
      logic [STEPS_W-1:0] bottom_left;
      logic [STEPS_W-1:0] bottom_right;
   } belt_counts_type;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int IDLE_MARGIN    = 2;
   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLD_OFF_SPAN  = 160;
   localparam int REPORT_LIMIT   = 10;
   localparam int CYCLE_LIMIT    = 300000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_POINTS   = 130;
   localparam int BURST_POINTS   = 80;

   // Register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam coord_type COORD_MAX = 24'h7FFFFF;
   localparam coord_type COORD_MIN = 24'h800000;
   localparam logic [CSR_DATA_W-1:0] OFFSET_FULL = 24'h7FFFFF;
   localparam logic [CSR_DATA_W-1:0] SPM_FULL    = 24'hFFFFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   coord_type              req_pos_x = '0;
   coord_type              req_pos_y = '0;
   coord_type              req_pos_z = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STEPS_W-1:0]     rsp_steps_top_left;
   logic [STEPS_W-1:0]     rsp_steps_top_right;
   logic [STEPS_W-1:0]     rsp_steps_bottom_left;
   logic [STEPS_W-1:0]     rsp_steps_bottom_right;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow copy of the frame registers
   rim_type             frame_x_min = EDGE_LOW_RESET;
   rim_type             frame_x_max = EDGE_HIGH_RESET;
   rim_type             frame_y_min = EDGE_LOW_RESET;
   rim_type             frame_y_max = EDGE_HIGH_RESET;
   logic [OFFSET_W-1:0] frame_offset = '0;
   logic [SPM_W-1:0]    frame_spm = SPM_RESET;

   belt_counts_type expected_counts[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              idling_on = 1'b1;
   bit              hold_off_pending = 1'b0;

   four_cable_inverse_kinematics_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_pos_x              (req_pos_x),
      .req_pos_y              (req_pos_y),
      .req_pos_z              (req_pos_z),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_steps_top_left     (rsp_steps_top_left),
      .rsp_steps_top_right    (rsp_steps_top_right),
      .rsp_steps_bottom_left  (rsp_steps_bottom_left),
      .rsp_steps_bottom_right (rsp_steps_bottom_right),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Integer square root, one result bit per pass from the top down
   function automatic u64_type floor_sqrt(u64_type radicand);
      u64_type root;
      u64_type trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (u64_type'(1) << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root;
   endfunction

   // Belt length from one corner, in motor steps
   function automatic logic [STEPS_W-1:0] corner_steps(coord_type px, coord_type py,
                                                        coord_type pz,
                                                        rim_type rim_x, rim_type rim_y);
      longint  dx;
      longint  dy;
      longint  dz;
      u64_type length_sq;
      u64_type root;
      u64_type scaled;
      dx = longint'(px) - longint'(rim_x);
      if (dx < 0) dx = -dx;
      dx = dx - longint'(frame_offset);
      dy = longint'(py) - longint'(rim_y);
      if (dy < 0) dy = -dy;
      dy = dy - longint'(frame_offset);
      dz = longint'(pz);
      length_sq = dx * dx + dy * dy + dz * dz;
      root = floor_sqrt(length_sq << 14);
      scaled = (root * u64_type'(frame_spm) + (u64_type'(1) << 30)) >> 31;
      if (scaled > u64_type'(STEP_MAX)) scaled = u64_type'(STEP_MAX);
      return scaled[STEPS_W-1:0];
   endfunction

   function automatic belt_counts_type belt_counts(coord_type px, coord_type py, coord_type pz);
      belt_counts_type counts;
      counts.top_left     = corner_steps(px, py, pz, frame_x_min, frame_y_max);
      counts.top_right    = corner_steps(px, py, pz, frame_x_max, frame_y_max);
      counts.bottom_left  = corner_steps(px, py, pz, frame_x_min, frame_y_min);
      counts.bottom_right = corner_steps(px, py, pz, frame_x_max, frame_y_min);
      return counts;
   endfunction

   function automatic void flag_mismatch(string detail);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", detail);
   endfunction

   function automatic void check_count(string corner, logic [STEPS_W-1:0] want,
                                       logic [STEPS_W-1:0] got);
      if (got !== want)
         flag_mismatch($sformatf("%s steps expected %0d, got %0d", corner, want, got));
   endfunction

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      belt_counts_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            flag_mismatch($sformatf("result with nothing expected: %0d %0d %0d %0d",
                                    rsp_steps_top_left, rsp_steps_top_right,
                                    rsp_steps_bottom_left, rsp_steps_bottom_right));
         end else begin
            want = expected_counts.pop_front();
            check_count("top left", want.top_left, rsp_steps_top_left);
            check_count("top right", want.top_right, rsp_steps_top_right);
            check_count("bottom left", want.bottom_left, rsp_steps_bottom_left);
            check_count("bottom right", want.bottom_right, rsp_steps_bottom_right);
         end
      end
   end

   // Output side: short random stalls, or one long hold-off on request
   initial begin : result_stall
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_SPAN) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Offer one point and hold it until the block takes it
   task automatic send_point(coord_type px, coord_type py, coord_type pz);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (req_stall);
      expected_counts.push_back(belt_counts(px, py, pz));
   endtask

   // Drop the request and wait until every prediction has been matched
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_counts.size() != 0);
      repeat (IDLE_MARGIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_X_MIN:         frame_x_min  = data;
         CSR_X_MAX:         frame_x_max  = data;
         CSR_Y_MIN:         frame_y_min  = data;
         CSR_Y_MAX:         frame_y_max  = data;
         CSR_CORNER_OFFSET: frame_offset = data[OFFSET_W-1:0];
         CSR_STEPS_PER_MM:  frame_spm    = data;
         default: ;
      endcase
   endtask

   task automatic configure(rim_type x_lo, rim_type x_hi, rim_type y_lo, rim_type y_hi,
                            logic [CSR_DATA_W-1:0] offset, logic [CSR_DATA_W-1:0] spm);
      write_reg(CSR_X_MIN, x_lo);
      write_reg(CSR_X_MAX, x_hi);
      write_reg(CSR_Y_MIN, y_lo);
      write_reg(CSR_Y_MAX, y_hi);
      write_reg(CSR_CORNER_OFFSET, offset);
      write_reg(CSR_STEPS_PER_MM, spm);
   endtask

   // Mix of full-range, extreme and near-origin coordinates
   function automatic coord_type random_coord();
      int near;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         1, 2: begin
            near = int'($urandom_range(0, 262143)) - 131072;
            return coord_type'(near);
         end
         default: return coord_type'($urandom());
      endcase
   endfunction

   task automatic send_random_point();
      send_point(random_coord(), random_coord(), random_coord());
   endtask

   // Field extremes under the reset frame
   task automatic test_extreme_points();
      send_point('0, '0, '0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX, '0);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN);
      send_point(-24'sd1, 24'sd1, -24'sd1);
   endtask

   // Register writes and the special cases they open up
   task automatic test_register_corner_cases();
      configure(-24'sd128000, 24'sd128000, -24'sd96000, 24'sd96000, 24'd5120,
                CSR_DATA_W'(80 * 65536));
      send_point('0, '0, '0);
      send_point(-24'sd128000, 24'sd96000, 24'sd2560);
      // offset beyond the edge distance gives a negative axis distance
      write_reg(CSR_CORNER_OFFSET, 24'd200000);
      send_point(coord_type'(-128000 + 256), coord_type'(96000 - 256), '0);
      write_reg(CSR_CORNER_OFFSET, OFFSET_FULL);
      send_point('0, '0, COORD_MAX);
      // zero steps per mm gives all zero counts
      write_reg(CSR_STEPS_PER_MM, '0);
      send_point(24'sd1000, -24'sd1000, 24'sd500);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      write_reg(CSR_STEPS_PER_MM, SPM_FULL);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN);
      // top bit of the offset data lies outside the register
      write_reg(CSR_CORNER_OFFSET, 24'h800000 | 24'd100);
      send_point(24'sd3000, 24'sd4000, -24'sd5000);
      // writes to undecoded indexes leave the frame alone
      write_reg(CSR_SPARE_LOW, 24'h123456);
      write_reg(CSR_SPARE_HIGH, 24'hABCDEF);
      send_point(24'sd3000, 24'sd4000, -24'sd5000);
      // swapped frame at the extremes
      configure(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, '0, 24'd1);
      send_point(COORD_MIN, COORD_MAX, '0);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN);
   endtask

   // Random points across a series of frame settings
   task automatic test_random_frames();
      int half_x;
      int half_y;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               half_x = $urandom_range(256, 400000);
               half_y = $urandom_range(256, 400000);
               configure(rim_type'(-half_x), rim_type'(half_x), rim_type'(-half_y),
                         rim_type'(half_y), CSR_DATA_W'($urandom_range(0, 12800)),
                         CSR_DATA_W'($urandom_range(65536, 200 * 65536)));
            end
            1: configure(rim_type'($urandom()), rim_type'($urandom()), rim_type'($urandom()),
                         rim_type'($urandom()), CSR_DATA_W'($urandom()),
                         CSR_DATA_W'($urandom()));
            2: configure(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, OFFSET_FULL, SPM_FULL);
            default: configure(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, '0, 24'd1);
         endcase
         repeat (PHASE_POINTS) send_random_point();
      end
   endtask

   // Hold off the output long enough that the pipeline fills and stalls its input
   task automatic test_output_hold_off();
      configure(-24'sd200000, 24'sd200000, -24'sd150000, 24'sd150000, 24'd2560,
                CSR_DATA_W'(100 * 65536));
      idling_on = 1'b0;
      hold_off_pending = 1'b1;
      repeat (BURST_POINTS) send_random_point();
      idling_on = 1'b1;
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_steady_stream();
      wait_idle();
      idling_on = 1'b0;
      repeat (BURST_POINTS) send_random_point();
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_points();
      test_register_corner_cases();
      test_random_frames();
      test_output_hold_off();
      test_steady_stream();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
